[hw/rtl/narp_pkg.sv]
// Shared types and constants of the note arpeggiator.
`timescale 1ns / 1ps

package narp_pkg;

   localparam int MAX_LIST = 8;
   localparam int POS_W    = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
   localparam int LEN_W    = $clog2(MAX_LIST + 1);

   localparam int NOTE_IN_W  = 16;
   localparam int NOTE_W     = 7;
   localparam int FRAMES_W   = 16;
   localparam int OPCODE_W   = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ARP_ENABLE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES_PER_STEP = 2'd1;

   localparam logic signed [NOTE_IN_W-1:0] NOTE_MAX       = 16'sd127;
   localparam logic [NOTE_IN_W-1:0]        HIGH_OFFSET    = 16'd116;
   localparam logic [NOTE_IN_W-1:0]        LOW_OFFSET     = 16'd11;
   localparam logic [NOTE_W-1:0]           FOLD_HIGH_BASE = 7'd116;
   localparam logic [NOTE_W-1:0]           FOLD_LOW_BASE  = 7'd11;

   // floor(x / 12) == (x * RECIP_12) >> RECIP_SHIFT for every 16-bit x
   localparam logic [15:0] RECIP_12    = 16'd43691;
   localparam int          RECIP_SHIFT = 19;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FOLD,
      ST_APPLY
   } narp_state_type;

   typedef enum logic [1:0] {
      FOLD_PASS,
      FOLD_HIGH,
      FOLD_LOW
   } narp_fold_type;

   typedef struct packed {
      logic capture;
      logic fold;
      logic apply;
   } narp_cmd_type;

   typedef struct packed {
      logic is_tick;
   } narp_status_type;

endpackage

[hw/rtl/note_arpeggiator.sv]
// Top level of the note arpeggiator: controller, datapath and configuration port.
`timescale 1ns / 1ps

// Plays a stored list of up to MAX_LIST MIDI notes, each held for frames_per_step
// ticks. An item is a tick, a list clear or a note append; only a tick returns a
// result, either the current list note or the octave-folded fallback note. Each
// item goes through capture, fold and apply after acceptance: folding into
// 0..127 goes through a registered reciprocal multiply before the table and the
// counters update, and the controller works on one item at a time. A tick result
// waits in an output register, so the next item is accepted while it is pending.
// Configuration writes are always ready and must come only while the block is idle.

module note_arpeggiator (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [narp_pkg::OPCODE_W-1:0]           req_opcode,
   input  logic signed [narp_pkg::NOTE_IN_W-1:0]   req_fallback_note,
   input  logic signed [narp_pkg::NOTE_IN_W-1:0]   req_new_note,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [narp_pkg::NOTE_W-1:0]             rsp_note_out,
   output logic                                    rsp_from_list,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [narp_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [narp_pkg::CSR_DATA_W-1:0]         csr_data
);

   narp_pkg::narp_cmd_type     cmd;
   narp_pkg::narp_status_type  status;

   assign csr_ready = 1'b1;

   narp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   narp_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_fallback_note (req_fallback_note),
      .req_new_note      (req_new_note),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_note_out      (rsp_note_out),
      .rsp_from_list     (rsp_from_list)
   );

endmodule

[hw/rtl/narp_dp.sv]
// Datapath of the note arpeggiator: note folding, note table, sequence state, result register.
`timescale 1ns / 1ps

module narp_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  narp_pkg::narp_cmd_type                  cmd,
   output narp_pkg::narp_status_type               status,
   input  logic [narp_pkg::OPCODE_W-1:0]           req_opcode,
   input  logic signed [narp_pkg::NOTE_IN_W-1:0]   req_fallback_note,
   input  logic signed [narp_pkg::NOTE_IN_W-1:0]   req_new_note,
   input  logic                                    csr_we,
   input  logic [narp_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [narp_pkg::CSR_DATA_W-1:0]         csr_data,
   output logic [narp_pkg::NOTE_W-1:0]             rsp_note_out,
   output logic                                    rsp_from_list
);

   logic [narp_pkg::OPCODE_W-1:0]          op_ff;
   logic signed [narp_pkg::NOTE_IN_W-1:0]  note_ff;

   logic [narp_pkg::NOTE_IN_W-1:0]  fold_x_in;
   logic [narp_pkg::NOTE_IN_W-1:0]  fold_x_ff;
   logic [31:0]                     fold_prod_in;
   logic [31:0]                     fold_prod_ff;
   narp_pkg::narp_fold_type         fold_mode_in;
   narp_pkg::narp_fold_type         fold_mode_ff;
   logic [narp_pkg::NOTE_W-1:0]     note_pass_ff;

   logic [12:0]                     quot;
   logic [narp_pkg::NOTE_IN_W-1:0]  quot12;
   logic [narp_pkg::NOTE_IN_W-1:0]  rem16;
   logic [narp_pkg::NOTE_W-1:0]     folded;

   logic [narp_pkg::NOTE_W-1:0]  note_table [narp_pkg::MAX_LIST];

   logic                            enable_ff;
   logic                            enable_in;
   logic [narp_pkg::FRAMES_W-1:0]   fps_ff;
   logic [narp_pkg::FRAMES_W-1:0]   fps_in;
   logic [narp_pkg::LEN_W-1:0]      len_ff;
   logic [narp_pkg::LEN_W-1:0]      len_in;
   logic [narp_pkg::POS_W-1:0]      pos_ff;
   logic [narp_pkg::POS_W-1:0]      pos_in;
   logic [narp_pkg::NOTE_W-1:0]     cur_ff;
   logic [narp_pkg::NOTE_W-1:0]     cur_in;
   logic                            valid_ff;
   logic                            valid_in;
   logic [narp_pkg::FRAMES_W-1:0]   count_ff;
   logic [narp_pkg::FRAMES_W-1:0]   count_in;

   logic [narp_pkg::NOTE_W-1:0]     rsp_note_ff;
   logic [narp_pkg::NOTE_W-1:0]     rsp_note_in;
   logic                            rsp_list_ff;
   logic                            rsp_list_in;

   logic [narp_pkg::LEN_W-1:0]      pos_inc;
   logic [narp_pkg::POS_W-1:0]      next_pos;
   logic [narp_pkg::POS_W-1:0]      rd_addr;
   logic [narp_pkg::NOTE_W-1:0]     rd_value;
   logic                            list_full;
   logic                            table_we;
   logic [narp_pkg::FRAMES_W-1:0]   csr_fps;

   // capture the item; keep only the note that the opcode folds
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_opcode;
         if (req_opcode == narp_pkg::OP_APPEND) begin
            note_ff <= req_new_note;
         end else begin
            note_ff <= req_fallback_note;
         end
      end
   end

   always_comb begin
      if (note_ff > narp_pkg::NOTE_MAX) begin
         fold_mode_in = narp_pkg::FOLD_HIGH;
         fold_x_in    = note_ff - narp_pkg::HIGH_OFFSET;
      end else if (note_ff[narp_pkg::NOTE_IN_W-1]) begin
         fold_mode_in = narp_pkg::FOLD_LOW;
         fold_x_in    = narp_pkg::LOW_OFFSET - note_ff;
      end else begin
         fold_mode_in = narp_pkg::FOLD_PASS;
         fold_x_in    = note_ff;
      end
      fold_prod_in = {16'd0, fold_x_in} * {16'd0, narp_pkg::RECIP_12};
   end

   always_ff @(posedge clock) begin
      if (cmd.fold) begin
         fold_x_ff    <= fold_x_in;
         fold_prod_ff <= fold_prod_in;
         fold_mode_ff <= fold_mode_in;
         note_pass_ff <= note_ff[narp_pkg::NOTE_W-1:0];
      end
   end

   // remainder by 12 from the registered quotient
   always_comb begin
      quot   = fold_prod_ff[31:narp_pkg::RECIP_SHIFT];
      quot12 = {quot, 3'b000} + {1'b0, quot, 2'b00};
      rem16  = fold_x_ff - quot12;
      case (fold_mode_ff)
         narp_pkg::FOLD_HIGH: folded = narp_pkg::FOLD_HIGH_BASE + {3'b000, rem16[3:0]};
         narp_pkg::FOLD_LOW:  folded = narp_pkg::FOLD_LOW_BASE - {3'b000, rem16[3:0]};
         default:             folded = note_pass_ff;
      endcase
   end

   always_comb begin
      pos_inc   = narp_pkg::LEN_W'(pos_ff) + narp_pkg::LEN_W'(1);
      next_pos  = (pos_inc == len_ff) ? '0 : pos_inc[narp_pkg::POS_W-1:0];
      rd_addr   = (count_ff == '0) ? next_pos : '0;
      rd_value  = note_table[rd_addr];
      list_full = (len_ff == narp_pkg::LEN_W'(narp_pkg::MAX_LIST));
      table_we  = cmd.apply && (op_ff == narp_pkg::OP_APPEND) && !list_full;
      csr_fps   = (csr_data == '0) ? narp_pkg::FRAMES_W'(1) : csr_data;
   end

   always_comb begin
      enable_in   = enable_ff;
      fps_in      = fps_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      valid_in    = valid_ff;
      count_in    = count_ff;
      rsp_note_in = rsp_note_ff;
      rsp_list_in = rsp_list_ff;
      if (cmd.apply) begin
         case (op_ff)
            narp_pkg::OP_TICK: begin
               if (!enable_ff || len_ff == '0) begin
                  rsp_note_in = folded;
                  rsp_list_in = 1'b0;
               end else begin
                  valid_in = 1'b1;
                  if (count_ff == '0) begin
                     pos_in   = next_pos;
                     cur_in   = rd_value;
                     count_in = fps_ff - narp_pkg::FRAMES_W'(1);
                  end else begin
                     if (!valid_ff) begin
                        cur_in = rd_value;
                     end
                     count_in = count_ff - narp_pkg::FRAMES_W'(1);
                  end
                  rsp_note_in = cur_in;
                  rsp_list_in = 1'b1;
               end
            end
            narp_pkg::OP_CLEAR: begin
               len_in   = '0;
               pos_in   = '0;
               cur_in   = '0;
               valid_in = 1'b0;
               count_in = '0;
            end
            narp_pkg::OP_APPEND: begin
               if (!list_full) begin
                  len_in = len_ff + narp_pkg::LEN_W'(1);
               end
               pos_in   = '0;
               cur_in   = (len_ff == '0) ? folded : note_table[0];
               valid_in = 1'b1;
               count_in = fps_ff;
            end
            default: begin
            end
         endcase
      end else if (csr_we) begin
         case (csr_index)
            narp_pkg::CSR_ARP_ENABLE: enable_in = csr_data[0];
            narp_pkg::CSR_FRAMES_PER_STEP: begin
               fps_in = csr_fps;
               if (count_ff > csr_fps) begin
                  count_in = csr_fps;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         fps_ff    <= narp_pkg::FRAMES_W'(1);
         len_ff    <= '0;
         pos_ff    <= '0;
         cur_ff    <= '0;
         valid_ff  <= 1'b0;
         count_ff  <= '0;
      end else begin
         enable_ff <= enable_in;
         fps_ff    <= fps_in;
         len_ff    <= len_in;
         pos_ff    <= pos_in;
         cur_ff    <= cur_in;
         valid_ff  <= valid_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (table_we) begin
         note_table[len_ff[narp_pkg::POS_W-1:0]] <= folded;
      end
      rsp_note_ff <= rsp_note_in;
      rsp_list_ff <= rsp_list_in;
   end

   assign status.is_tick = (op_ff == narp_pkg::OP_TICK);
   assign rsp_note_out   = rsp_note_ff;
   assign rsp_from_list  = rsp_list_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= narp_pkg::LEN_W'(narp_pkg::MAX_LIST))
      else $error("list length beyond table size");

   a_pos_in_list: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) |-> (narp_pkg::LEN_W'(pos_ff) < len_ff))
      else $error("step position outside the list");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fps_ff)
      else $error("frame countdown above frames per step");

endmodule

[hw/rtl/narp_ctrl.sv]
// Controller of the note arpeggiator: item sequencing and result valid.
`timescale 1ns / 1ps

module narp_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output narp_pkg::narp_cmd_type     cmd,
   input  narp_pkg::narp_status_type  status
);

   narp_pkg::narp_state_type  state_ff;
   narp_pkg::narp_state_type  state_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= narp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         narp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = narp_pkg::ST_FOLD;
            end
         end
         narp_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = narp_pkg::ST_APPLY;
         end
         narp_pkg::ST_APPLY: begin
            // hold while a tick result would overwrite one not yet taken
            if (!(status.is_tick && rsp_valid_ff && !rsp_ready)) begin
               cmd.apply = 1'b1;
               state_in  = narp_pkg::ST_IDLE;
               if (status.is_tick) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = narp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_fold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == narp_pkg::ST_FOLD))
      else $error("accepted item did not enter fold");

   a_fold_to_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == narp_pkg::ST_FOLD) |=> (state_ff == narp_pkg::ST_APPLY))
      else $error("fold not followed by apply");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && status.is_tick) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

endmodule
